### hw/rtl/fcct_pkg.sv
package fcct_pkg;

    // default table depth and register reset values
    localparam int unsigned TABLE_ENTRIES_DEF = 16384;
    localparam logic [31:0] END_MARK_RST      = 32'h0FFF_FFFF;
    localparam logic [13:0] SCAN_LIMIT_RST    = 14'd10001;
    localparam int unsigned FIRST_DATA_CLUSTER = 2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARK   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_ALLOC = 2'd2,
        OP_FREE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NO_FREE = 2'd1,
        STAT_RANGE   = 2'd2,
        STAT_LOOP    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_ALLOC,
        ST_FREE_CHK,
        ST_FREE_RD
    } t_state;

    // table address source
    typedef enum logic [2:0] {
        AS_CLEAR,
        AS_IN_CLUSTER,
        AS_ALLOC_FIRST,
        AS_PTR,
        AS_PTR_NEXT,
        AS_REQ,
        AS_CUR
    } t_addr_sel;

    typedef enum logic [1:0] {
        WD_ZERO,
        WD_VALUE,
        WD_END_MARK
    } t_wdata_sel;

    typedef enum logic [1:0] {
        RS_ZERO,
        RS_RDATA,
        RS_PTR
    } t_res_sel;

    // commands from controller to datapath
    typedef struct packed {
        logic       mem_re;
        logic       mem_we;
        t_addr_sel  addr_sel;
        t_wdata_sel wdata_sel;
        logic       load_req;
        logic       ptr_inc;
        logic       cur_load;
        logic       clr_inc;
        logic       finish;
        t_res_sel   res_sel;
        t_status    fin_status;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic req_range;
        logic clr_last;
        logic rd_zero;
        logic ptr_past_top;
        logic ptr_at_top;
        logic cur_end;
        logic cur_range;
        logic steps_max;
        logic out_free;
    } t_dp_stat;

endpackage

### hw/rtl/fcct_dp.sv
module fcct_dp #(
    parameter int unsigned TABLE_ENTRIES = fcct_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [fcct_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                        i_cfg_data,
    input  logic [13:0]                        i_cluster,
    input  logic [31:0]                        i_value,
    input  logic                               i_out_stall,
    input  fcct_pkg::t_dp_cmd                  i_cmd,
    output fcct_pkg::t_dp_stat                 o_stat,
    output logic                               o_out_valid,
    output logic [31:0]                        o_result_value,
    output logic [1:0]                         o_status
);
    import fcct_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_ENTRIES);
    localparam logic [31:0] TE32 = 32'(TABLE_ENTRIES);

    // cluster table, single port
    logic [31:0] mem [TABLE_ENTRIES];
    logic [31:0] r_rdata;

    logic [31:0]   r_end_mark;
    logic [13:0]   r_scan_limit;
    logic [13:0]   r_cluster;
    logic [31:0]   r_value;
    logic [AW-1:0] r_ptr;
    logic [31:0]   r_cur;
    logic [AW:0]   r_steps;
    logic [AW-1:0] r_clr;
    logic          r_out_valid;
    logic [31:0]   r_result_value;
    t_status       r_status;

    logic [AW-1:0] w_addr;
    logic [31:0]   w_wdata;
    logic [31:0]   w_in_cl32;
    logic [31:0]   w_req_cl32;
    logic [31:0]   w_scan32;
    logic [AW-1:0] w_top;
    logic [31:0]   w_res;
    logic          w_out_free;

    assign w_in_cl32  = {18'b0, i_cluster};
    assign w_req_cl32 = {18'b0, r_cluster};
    assign w_scan32   = {18'b0, r_scan_limit};

    // allocator bound: smaller of scan limit and last entry
    assign w_top = (w_scan32 > TE32 - 32'd1) ? AW'(TABLE_ENTRIES - 1) : w_scan32[AW-1:0];

    // table address and write data
    always_comb begin
        case (i_cmd.addr_sel)
            AS_CLEAR:       w_addr = r_clr;
            AS_IN_CLUSTER:  w_addr = w_in_cl32[AW-1:0];
            AS_ALLOC_FIRST: w_addr = AW'(FIRST_DATA_CLUSTER);
            AS_PTR:         w_addr = r_ptr;
            AS_PTR_NEXT:    w_addr = r_ptr + AW'(1);
            AS_REQ:         w_addr = w_req_cl32[AW-1:0];
            AS_CUR:         w_addr = r_cur[AW-1:0];
            default:        w_addr = r_ptr;
        endcase
    end

    always_comb begin
        case (i_cmd.wdata_sel)
            WD_ZERO:     w_wdata = 32'd0;
            WD_VALUE:    w_wdata = r_value;
            WD_END_MARK: w_wdata = r_end_mark;
            default:     w_wdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            mem[w_addr] <= w_wdata;
        end
        if (i_cmd.mem_re) begin
            r_rdata <= mem[w_addr];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_mark   <= END_MARK_RST;
            r_scan_limit <= SCAN_LIMIT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_END_MARK) begin
                r_end_mark <= i_cfg_data;
            end
            if (i_cfg_index == CFG_SCAN_LIMIT) begin
                r_scan_limit <= i_cfg_data[13:0];
            end
        end
    end

    // clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_inc) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    // request, scan pointer and chain walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_cluster <= i_cluster;
            r_value   <= i_value;
            r_ptr     <= AW'(FIRST_DATA_CLUSTER);
            r_cur     <= w_in_cl32;
            r_steps   <= '0;
        end else begin
            if (i_cmd.ptr_inc) begin
                r_ptr <= r_ptr + AW'(1);
            end
            if (i_cmd.cur_load) begin
                r_cur   <= r_rdata;
                r_steps <= r_steps + (AW+1)'(1);
            end
        end
    end

    // result register
    always_comb begin
        case (i_cmd.res_sel)
            RS_ZERO:  w_res = 32'd0;
            RS_RDATA: w_res = r_rdata;
            RS_PTR:   w_res = 32'(r_ptr);
            default:  w_res = 32'd0;
        endcase
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_result_value <= w_res;
            r_status       <= i_cmd.fin_status;
        end
    end

    // status toward the controller
    always_comb begin
        o_stat.req_range    = w_req_cl32 >= TE32;
        o_stat.clr_last     = r_clr == AW'(TABLE_ENTRIES - 1);
        o_stat.rd_zero      = r_rdata == 32'd0;
        o_stat.ptr_past_top = r_ptr > w_top;
        o_stat.ptr_at_top   = r_ptr >= w_top;
        o_stat.cur_end      = (r_cur == 32'd0) || (r_cur == r_end_mark);
        o_stat.cur_range    = r_cur >= TE32;
        o_stat.steps_max    = r_steps == (AW+1)'(TABLE_ENTRIES);
        o_stat.out_free     = w_out_free;
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_result_value;
    assign o_status       = r_status;

endmodule

### hw/rtl/fcct_ctrl.sv
module fcct_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [1:0]         i_operation,
    input  fcct_pkg::t_dp_stat i_stat,
    output logic               o_in_stall,
    output fcct_pkg::t_dp_cmd  o_cmd
);
    import fcct_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_stat.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (t_op'(i_operation))
                        OP_READ:  n_state = ST_READ;
                        OP_WRITE: n_state = ST_WRITE;
                        OP_ALLOC: n_state = ST_ALLOC;
                        OP_FREE:  n_state = ST_FREE_CHK;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_READ, ST_WRITE: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            ST_ALLOC: begin
                if (i_stat.ptr_past_top || i_stat.rd_zero || i_stat.ptr_at_top) begin
                    if (i_stat.out_free) n_state = ST_IDLE;
                end
            end
            ST_FREE_CHK: begin
                if (i_stat.cur_end || i_stat.cur_range || i_stat.steps_max) begin
                    if (i_stat.out_free) n_state = ST_IDLE;
                end else begin
                    n_state = ST_FREE_RD;
                end
            end
            ST_FREE_RD: n_state = ST_FREE_CHK;
            default:    n_state = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd            = '0;
        o_cmd.addr_sel   = AS_CLEAR;
        o_cmd.wdata_sel  = WD_ZERO;
        o_cmd.res_sel    = RS_ZERO;
        o_cmd.fin_status = STAT_OK;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.mem_we  = 1'b1;
                o_cmd.clr_inc = 1'b1;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    if (t_op'(i_operation) == OP_READ) begin
                        o_cmd.mem_re   = 1'b1;
                        o_cmd.addr_sel = AS_IN_CLUSTER;
                    end
                    if (t_op'(i_operation) == OP_ALLOC) begin
                        o_cmd.mem_re   = 1'b1;
                        o_cmd.addr_sel = AS_ALLOC_FIRST;
                    end
                end
            end
            ST_READ: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    if (i_stat.req_range) begin
                        o_cmd.fin_status = STAT_RANGE;
                    end else begin
                        o_cmd.res_sel = RS_RDATA;
                    end
                end
            end
            ST_WRITE: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    if (i_stat.req_range) begin
                        o_cmd.fin_status = STAT_RANGE;
                    end else begin
                        o_cmd.mem_we    = 1'b1;
                        o_cmd.addr_sel  = AS_REQ;
                        o_cmd.wdata_sel = WD_VALUE;
                    end
                end
            end
            ST_ALLOC: begin
                if (i_stat.ptr_past_top) begin
                    o_cmd.finish     = i_stat.out_free;
                    o_cmd.fin_status = STAT_NO_FREE;
                end else if (i_stat.rd_zero) begin
                    if (i_stat.out_free) begin
                        o_cmd.finish    = 1'b1;
                        o_cmd.res_sel   = RS_PTR;
                        o_cmd.mem_we    = 1'b1;
                        o_cmd.addr_sel  = AS_PTR;
                        o_cmd.wdata_sel = WD_END_MARK;
                    end
                end else if (i_stat.ptr_at_top) begin
                    o_cmd.finish     = i_stat.out_free;
                    o_cmd.fin_status = STAT_NO_FREE;
                end else begin
                    o_cmd.ptr_inc  = 1'b1;
                    o_cmd.mem_re   = 1'b1;
                    o_cmd.addr_sel = AS_PTR_NEXT;
                end
            end
            ST_FREE_CHK: begin
                if (i_stat.cur_end) begin
                    o_cmd.finish = i_stat.out_free;
                end else if (i_stat.cur_range) begin
                    o_cmd.finish     = i_stat.out_free;
                    o_cmd.fin_status = STAT_RANGE;
                end else if (i_stat.steps_max) begin
                    o_cmd.finish     = i_stat.out_free;
                    o_cmd.fin_status = STAT_LOOP;
                end else begin
                    o_cmd.mem_re   = 1'b1;
                    o_cmd.addr_sel = AS_CUR;
                end
            end
            ST_FREE_RD: begin
                o_cmd.mem_we    = 1'b1;
                o_cmd.addr_sel  = AS_CUR;
                o_cmd.wdata_sel = WD_ZERO;
                o_cmd.cur_load  = 1'b1;
            end
            default: begin
                o_cmd.addr_sel = AS_CLEAR;
            end
        endcase
    end

    assign o_in_stall = r_state != ST_IDLE;

`ifndef SYNTHESIS
    // single table port: never read and write together
    a_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.mem_we && o_cmd.mem_re))
        else $error("table read and write in the same cycle");

    // a result is only loaded into a free output register
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_stat.out_free)
        else $error("result loaded over a waiting result");

    // clearing pass only ends into idle
    a_clear_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |=> (r_state == ST_CLEAR || r_state == ST_IDLE))
        else $error("clearing pass left to a busy state");

    // an accepted request always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid) |=> (r_state != ST_IDLE))
        else $error("accepted request did not start");
`endif

endmodule

### hw/rtl/fat_cluster_chain_table.sv
// channel   direction  handshake                 payload
// config    in         i_cfg_we                  i_cfg_index, i_cfg_data
// request   in         i_in_valid / o_in_stall   i_operation, i_cluster, i_value
// result    out        o_out_valid / i_out_stall o_result_value, o_status
//
// after reset a clearing pass zeroes the table, request stalled
// one request at a time: allocate examines one entry after another, and free
// reads then zeroes each chain link in turn (read then zero, single port)
// the result waits in an output register, a new request is taken meanwhile
// reset is synchronous, active low; config is taken at any time
module fat_cluster_chain_table #(
    parameter int unsigned TABLE_ENTRIES = fcct_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fcct_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_operation,
    input  logic [13:0]                    i_cluster,
    input  logic [31:0]                    i_value,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [31:0]                    o_result_value,
    output logic [1:0]                     o_status
);
    import fcct_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer
    fcct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_stat      (w_stat),
        .o_in_stall  (o_in_stall),
        .o_cmd       (w_cmd)
    );

    // table, registers and result
    fcct_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cluster      (i_cluster),
        .i_value        (i_value),
        .i_out_stall    (i_out_stall),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_out_valid    (o_out_valid),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

endmodule
